// File: rtl/psp_pkg.sv
// Shared types and field widths of the system call profile table.
`default_nettype none

package psp_pkg;

	localparam int PID_W      = 32;
	localparam int CALL_NUM_W = 32;
	localparam int COUNT_W    = 32;
	localparam int SLOT_W     = 8;
	localparam int RES_W      = 1 + 1 + SLOT_W + COUNT_W + 1;
	localparam int RES_PAD_W  = ((RES_W + 7) / 8) * 8;

	localparam logic REQ_TRACE    = 1'b0;
	localparam logic REQ_EVALUATE = 1'b1;

	localparam logic VERDICT_ALLOW = 1'b0;
	localparam logic VERDICT_DENY  = 1'b1;

	// First member in the highest bits, so verdict lands in bit 0.
	typedef struct packed {
		logic                table_full;
		logic [COUNT_W-1:0]  call_count;
		logic [SLOT_W-1:0]   slot;
		logic                hit;
		logic                verdict;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/process_syscall_profile_table_unit.sv
// Top level: process id lookup and per-process system call counter table.
// A hit passes through ST_SCAN, ST_MULT, ST_READ, ST_UPDATE and ST_DONE; a creating miss
// through ST_SCAN, ST_MULT, ST_CLEAR and ST_DONE; any other miss from ST_SCAN to ST_DONE.
// One word is in flight at a time; the id scan reads one stored id per cycle.
// Reset clears the entry count and all control state; the memories are not cleared, and a
// profile's counters are swept when it is created: zero, and one in the counted call's slot.
`default_nettype none

module process_syscall_profile_table_unit #(
	parameter int MAX_ENTRIES = 256,
	parameter int CALL_SLOTS  = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input words.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // proc_id [31:0], call_number [63:32]
	input  wire logic        s_tuser,   // req_type [0]
	// Result words.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata    // verdict [0], hit [1], slot [9:2],
	                                    // call_count [41:10], table_full [42], zero pad
);

	localparam int PID_W     = psp_pkg::PID_W;
	localparam int COUNT_W   = psp_pkg::COUNT_W;
	localparam int SLOT_W    = psp_pkg::SLOT_W;
	localparam int RES_W     = psp_pkg::RES_W;
	localparam int PAD_W     = psp_pkg::RES_PAD_W;
	localparam int IDX_W     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);
	localparam int CALL_W    = (CALL_SLOTS > 1) ? $clog2(CALL_SLOTS) : 1;
	localparam int CNT_DEPTH = MAX_ENTRIES * CALL_SLOTS;
	localparam int ADDR_W    = (CNT_DEPTH > 1) ? $clog2(CNT_DEPTH) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MULT,
		ST_READ,
		ST_UPDATE,
		ST_CLEAR,
		ST_DONE
	} state_t;

	// Stored process ids, one per profile, and the profile counters, row after row.
	logic [PID_W-1:0]   pid_mem [MAX_ENTRIES];
	logic [COUNT_W-1:0] cnt_mem [CNT_DEPTH];

	state_t             state_q;
	logic [CNT_W-1:0]   used_q;
	logic [CNT_W-1:0]   rd_idx_q;
	logic               cmp_vld_s1;
	logic [IDX_W-1:0]   cmp_idx_s1;
	logic [PID_W-1:0]   pid_rd_s1;
	logic [COUNT_W-1:0] cnt_rd_s1;
	logic [ADDR_W-1:0]  cnt_addr_s1;

	logic               req_q;
	logic [PID_W-1:0]   key_q;
	logic [CALL_W-1:0]  call_idx_q;
	logic               in_range_q;
	logic [IDX_W-1:0]   idx_q;
	logic               hit_q;
	logic               verdict_q;
	logic               full_q;
	logic [COUNT_W-1:0] count_q;
	logic [ADDR_W-1:0]  base_q;
	logic [CALL_W-1:0]  clr_k_q;

	logic               rd_en;
	logic               match;
	logic               scan_end;
	logic               create;
	logic               res_load;
	logic [ADDR_W-1:0]  cnt_ra;
	logic               cnt_re;
	logic               cnt_we;
	logic [ADDR_W-1:0]  cnt_wa;
	logic [COUNT_W-1:0] cnt_wd;
	logic [COUNT_W-1:0] cnt_inc;
	psp_pkg::result_t   result;

	// A new word is taken whenever no lookup is running; a result still waiting in the
	// output register does not hold the input back.
	assign s_tready = (state_q == ST_IDLE);

	// The scan reads one stored id per cycle and compares it in the next one, so a read and
	// a compare overlap. The scan ends when no read was issued last cycle and none is left.
	assign rd_en    = (state_q == ST_SCAN) && (rd_idx_q < used_q);
	assign match    = (state_q == ST_SCAN) && cmp_vld_s1 && (pid_rd_s1 == key_q);
	assign scan_end = (state_q == ST_SCAN) && !cmp_vld_s1 && (rd_idx_q >= used_q);
	assign create   = scan_end && (req_q == psp_pkg::REQ_TRACE)
	                  && (used_q < CNT_W'(MAX_ENTRIES));

	// The finished result moves into the output register once that register is free or
	// being emptied in the same cycle.
	assign res_load = (state_q == ST_DONE) && (!m_tvalid || m_tready);

	// Counter access: read in ST_READ, write back in ST_UPDATE; the clearing sweep writes
	// zero to every counter of a new profile, and one into the counted call's slot if in range.
	assign cnt_ra  = base_q + ADDR_W'(call_idx_q);
	assign cnt_re  = (state_q == ST_READ);
	assign cnt_inc = (cnt_rd_s1 == '1) ? cnt_rd_s1 : cnt_rd_s1 + COUNT_W'(1);

	always_comb begin
		cnt_we = 1'b0;
		cnt_wa = cnt_addr_s1;
		cnt_wd = cnt_inc;
		if (state_q == ST_CLEAR) begin
			cnt_we = 1'b1;
			cnt_wa = base_q + ADDR_W'(clr_k_q);
			cnt_wd = COUNT_W'(in_range_q && (clr_k_q == call_idx_q));
		end else if (state_q == ST_UPDATE) begin
			cnt_we = (req_q == psp_pkg::REQ_TRACE) && in_range_q;
		end
	end

	always_comb begin
		result.verdict    = verdict_q;
		result.hit        = hit_q;
		result.slot       = SLOT_W'(idx_q);
		result.call_count = count_q;
		result.table_full = full_q;
	end

	// Id memory: written once when a profile is created, read during the scan.
	always_ff @(posedge clk) begin
		if (create) begin
			pid_mem[used_q[IDX_W-1:0]] <= key_q;
		end
		if (rd_en) begin
			pid_rd_s1 <= pid_mem[rd_idx_q[IDX_W-1:0]];
		end
	end

	// Counter memory: one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_wa] <= cnt_wd;
		end
		if (cnt_re) begin
			cnt_rd_s1 <= cnt_mem[cnt_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			rd_idx_q    <= '0;
			cmp_vld_s1  <= 1'b0;
			cmp_idx_s1  <= '0;
			cnt_addr_s1 <= '0;
			req_q       <= psp_pkg::REQ_TRACE;
			key_q       <= '0;
			call_idx_q  <= '0;
			in_range_q  <= 1'b0;
			idx_q       <= '0;
			hit_q       <= 1'b0;
			verdict_q   <= psp_pkg::VERDICT_ALLOW;
			full_q      <= 1'b0;
			count_q     <= '0;
			base_q      <= '0;
			clr_k_q     <= '0;
			m_tvalid    <= 1'b0;
			m_tdata     <= '0;
		end else begin
			if (res_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						req_q      <= s_tuser;
						key_q      <= s_tdata[31:0];
						call_idx_q <= s_tdata[32 +: CALL_W];
						in_range_q <= (s_tdata[63:32] < 32'(CALL_SLOTS));
						rd_idx_q   <= '0;
						cmp_vld_s1 <= 1'b0;
						idx_q      <= '0;
						hit_q      <= 1'b0;
						verdict_q  <= psp_pkg::VERDICT_ALLOW;
						full_q     <= 1'b0;
						count_q    <= '0;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					cmp_vld_s1 <= rd_en && !match;
					cmp_idx_s1 <= rd_idx_q[IDX_W-1:0];
					if (rd_en) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
					end
					if (match) begin
						// Lowest matching index wins, as the scan runs upwards.
						hit_q      <= 1'b1;
						idx_q      <= cmp_idx_s1;
						state_q    <= ST_MULT;
					end else if (scan_end) begin
						if (req_q == psp_pkg::REQ_EVALUATE) begin
							verdict_q <= psp_pkg::VERDICT_DENY;
							state_q   <= ST_DONE;
						end else if (create) begin
							idx_q   <= used_q[IDX_W-1:0];
							used_q  <= used_q + CNT_W'(1);
							count_q <= COUNT_W'(in_range_q);
							state_q <= ST_MULT;
						end else begin
							full_q  <= 1'b1;
							state_q <= ST_DONE;
						end
					end
				end
				ST_MULT: begin
					base_q  <= ADDR_W'(idx_q * CALL_SLOTS);
					clr_k_q <= '0;
					state_q <= hit_q ? ST_READ : ST_CLEAR;
				end
				ST_READ: begin
					cnt_addr_s1 <= cnt_ra;
					state_q     <= ST_UPDATE;
				end
				ST_UPDATE: begin
					if (in_range_q) begin
						count_q <= (req_q == psp_pkg::REQ_EVALUATE) ? cnt_rd_s1 : cnt_inc;
					end
					state_q <= ST_DONE;
				end
				ST_CLEAR: begin
					clr_k_q <= clr_k_q + CALL_W'(1);
					if (clr_k_q == CALL_W'(CALL_SLOTS - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_load) begin
						m_tdata  <= {{(PAD_W - RES_W){1'b0}}, result};
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: test/tb_top.sv
// Self-checking testbench for the system call profile table: stream driver, monitor and predictor.

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH  = 256;
	localparam int CALL_SLOTS   = 64;
	localparam int RANDOM_WORDS = 1640;
	// The slowest correct word is a creating miss on a nearly full table, plus
	// receiver stalls; the limit is several times that per word.
	localparam int LIMIT_CYCLES = 2_000_000;
	// Settling time after the last result, longer than the slowest word.
	localparam int DRAIN_CYCLES = 400;

	// One input word as the generator sees it.
	typedef struct packed {
		logic                           req;
		logic [psp_pkg::PID_W-1:0]      pid;
		logic [psp_pkg::CALL_NUM_W-1:0] call;
	} syscall_event_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata  = '0;
	logic        s_tuser  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;

	process_syscall_profile_table_unit #(
		.MAX_ENTRIES(TABLE_DEPTH),
		.CALL_SLOTS (CALL_SLOTS)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	// Words still to be driven, and results the predictor has worked out but
	// the block has not yet delivered.
	syscall_event_t    event_q[$];
	psp_pkg::result_t  outcome_q[$];

	int errors      = 0;
	int words_in    = 0;
	int total_words = 0;
	int cycles      = 0;
	logic word_taken = 1'b0;

	// Predictor state: the stored process ids in creation order, how many
	// profiles exist, and the per-profile call counters.
	logic [psp_pkg::PID_W-1:0]   table_pid [TABLE_DEPTH];
	int                          profiles = 0;
	logic [psp_pkg::COUNT_W-1:0] call_tally [TABLE_DEPTH*CALL_SLOTS];

	// Generator bookkeeping: ids it has traced, and those that hold a profile.
	bit                        pid_taken [logic [psp_pkg::PID_W-1:0]];
	logic [psp_pkg::PID_W-1:0] traced_pids[$];

	initial forever #6 clk = ~clk;

	// Bumps one counter, saturating at all ones; numbers outside the profile
	// are not counted and read as zero.
	function automatic logic [psp_pkg::COUNT_W-1:0] count_call(int entry,
			logic [psp_pkg::CALL_NUM_W-1:0] call);
		int ix;
		if (call >= CALL_SLOTS)
			return '0;
		ix = entry * CALL_SLOTS + int'(call);
		if (call_tally[ix] != '1)
			call_tally[ix] = call_tally[ix] + 1'b1;
		return call_tally[ix];
	endfunction

	// Works out the result word of one accepted request and updates the
	// predictor's table the way the block should.
	function automatic psp_pkg::result_t profile_outcome(syscall_event_t ev);
		psp_pkg::result_t r;
		bit               found;
		int               entry;
		int               k;
		r     = '0;
		found = 1'b0;
		entry = 0;
		// The first matching entry wins; duplicates never get created anyway.
		for (k = 0; k < profiles; k++) begin
			if (!found && table_pid[k] == ev.pid) begin
				found = 1'b1;
				entry = k;
			end
		end
		if (ev.req == psp_pkg::REQ_TRACE) begin
			r.verdict = psp_pkg::VERDICT_ALLOW;
			if (found) begin
				r.hit        = 1'b1;
				r.slot       = psp_pkg::SLOT_W'(entry);
				r.call_count = count_call(entry, ev.call);
			end else if (profiles < TABLE_DEPTH) begin
				// A new profile starts with every counter cleared.
				entry            = profiles;
				table_pid[entry] = ev.pid;
				profiles++;
				for (k = 0; k < CALL_SLOTS; k++)
					call_tally[entry * CALL_SLOTS + k] = '0;
				r.slot       = psp_pkg::SLOT_W'(entry);
				r.call_count = count_call(entry, ev.call);
			end else begin
				// No room: the event is dropped and the table reports full.
				r.table_full = 1'b1;
			end
		end else begin
			if (found) begin
				r.verdict = psp_pkg::VERDICT_ALLOW;
				r.hit     = 1'b1;
				r.slot    = psp_pkg::SLOT_W'(entry);
				if (ev.call < CALL_SLOTS)
					r.call_count = call_tally[entry * CALL_SLOTS + int'(ev.call)];
			end else begin
				r.verdict = psp_pkg::VERDICT_DENY;
			end
		end
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	// Queues one word and keeps the generator's view of the table in step.
	// Only the first TABLE_DEPTH distinct traced ids ever get a profile.
	task automatic queue_event(logic req, logic [psp_pkg::PID_W-1:0] pid,
			logic [psp_pkg::CALL_NUM_W-1:0] call);
		syscall_event_t ev;
		ev.req  = req;
		ev.pid  = pid;
		ev.call = call;
		event_q.push_back(ev);
		if (req == psp_pkg::REQ_TRACE && !pid_taken.exists(pid)) begin
			pid_taken[pid] = 1'b1;
			if (traced_pids.size() < TABLE_DEPTH)
				traced_pids.push_back(pid);
		end
	endtask

	function automatic logic [psp_pkg::PID_W-1:0] fresh_pid();
		logic [psp_pkg::PID_W-1:0] p;
		do
			p = $urandom;
		while (pid_taken.exists(p));
		return p;
	endfunction

	// Mostly numbers inside the profile, with the boundary and wide values
	// mixed in so that every bit of the field moves.
	function automatic logic [psp_pkg::CALL_NUM_W-1:0] pick_call();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return $urandom_range(CALL_SLOTS - 1);
		else if (r < 80)
			return (r < 75) ? CALL_SLOTS - 1 : CALL_SLOTS;
		else
			return $urandom;
	endfunction

	// Most hits go to a handful of hot profiles so that counters climb well
	// past one; the rest spread over the whole table.
	function automatic logic [psp_pkg::PID_W-1:0] known_pid();
		int hot;
		hot = (traced_pids.size() < 8) ? traced_pids.size() : 8;
		if ($urandom_range(3) == 0)
			return traced_pids[$urandom_range(traced_pids.size() - 1)];
		return traced_pids[$urandom_range(hot - 1)];
	endfunction

	// Stimulus and end of run.
	initial begin
		int n;
		int r;

		// Directed part on an empty table: an unknown id is denied, then two
		// profiles at the id extremes exercise the call number edges, the
		// uncounted number on a creating miss, and evaluation of a known id.
		queue_event(psp_pkg::REQ_EVALUATE, 32'h0000_0000, 32'h0000_0000);
		queue_event(psp_pkg::REQ_TRACE,    32'h0000_0000, 32'h0000_0000);
		queue_event(psp_pkg::REQ_TRACE,    32'h0000_0000, 32'h0000_0000);
		queue_event(psp_pkg::REQ_TRACE,    32'h0000_0000, CALL_SLOTS - 1);
		queue_event(psp_pkg::REQ_TRACE,    32'h0000_0000, CALL_SLOTS);
		queue_event(psp_pkg::REQ_TRACE,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_event(psp_pkg::REQ_TRACE,    32'hFFFF_FFFF, CALL_SLOTS - 1);
		queue_event(psp_pkg::REQ_EVALUATE, 32'h0000_0000, 32'h0000_0000);
		queue_event(psp_pkg::REQ_EVALUATE, 32'h0000_0000, 32'hFFFF_FFFF);
		queue_event(psp_pkg::REQ_EVALUATE, 32'hFFFF_FFFF, 32'h0000_0001);
		queue_event(psp_pkg::REQ_EVALUATE, 32'h8000_0000, 32'h0000_0005);
		queue_event(psp_pkg::REQ_TRACE,    32'h5555_5555, 32'hAAAA_AAAA);
		queue_event(psp_pkg::REQ_TRACE,    32'hAAAA_AAAA, 32'h5555_5555);
		queue_event(psp_pkg::REQ_EVALUATE, 32'hAAAA_AAAA, 32'h0000_0000);
		// A counter at its maximum cannot be reached from the ports in any
		// sensible run time, so saturation is left to the predictor alone.

		// Random part. A quarter of the words trace a fresh id, so the table
		// fills part way through and the later fresh ids are dropped as full.
		for (n = 0; n < RANDOM_WORDS; n++) begin
			r = $urandom_range(99);
			if (traced_pids.size() == 0 || r < 25)
				queue_event(psp_pkg::REQ_TRACE, fresh_pid(), pick_call());
			else if (r < 33)
				queue_event(psp_pkg::REQ_EVALUATE, fresh_pid(), pick_call());
			else if (r < 55)
				queue_event(psp_pkg::REQ_EVALUATE, known_pid(), pick_call());
			else
				queue_event(psp_pkg::REQ_TRACE, known_pid(), pick_call());
		end
		total_words = event_q.size();

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (event_q.size() != 0 || s_tvalid || outcome_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	// Driver: inputs move on the falling edge. The idling mix follows the
	// progress of the run: receiver idle first, then sender idle, then none.
	always @(negedge clk or negedge arst_n) begin
		int tx_idle;
		int rx_idle;
		syscall_event_t ev;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= 1'b0;
			m_tready <= 1'b0;
		end else begin
			if (words_in < total_words / 3) begin
				tx_idle = 20;
				rx_idle = 58;
			end else if (words_in < 2 * total_words / 3) begin
				tx_idle = 58;
				rx_idle = 20;
			end else begin
				tx_idle = 0;
				rx_idle = 0;
			end
			// A word on offer stays put until it has been taken.
			if (!s_tvalid || word_taken) begin
				if (event_q.size() != 0 && $urandom_range(99) >= tx_idle) begin
					ev = event_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {ev.call, ev.pid};
					s_tuser  <= ev.req;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= ($urandom_range(99) >= rx_idle);
		end
	end

	// Monitor: both handshakes are sampled on the rising edge. The result is
	// checked before the input word is predicted, so an empty store of
	// expectations is never read in the middle of an update.
	always @(posedge clk) begin
		psp_pkg::result_t got;
		psp_pkg::result_t want;
		syscall_event_t   ev;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = psp_pkg::result_t'(m_tdata[psp_pkg::RES_W-1:0]);
				if (outcome_q.size() == 0) begin
					$error("result word %0h arrived with no request outstanding", m_tdata);
					errors++;
				end else begin
					want = outcome_q.pop_front();
					check_field("verdict",    want.verdict,    got.verdict);
					check_field("hit",        want.hit,        got.hit);
					check_field("slot",       want.slot,       got.slot);
					check_field("call_count", want.call_count, got.call_count);
					check_field("table_full", want.table_full, got.table_full);
				end
			end
			if (s_tvalid && s_tready) begin
				ev.req  = s_tuser;
				ev.pid  = s_tdata[31:0];
				ev.call = s_tdata[63:32];
				outcome_q.push_back(profile_outcome(ev));
				words_in++;
			end
			word_taken <= s_tvalid && s_tready;
		end
	end

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		cycles++;
		if (cycles == LIMIT_CYCLES) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

endmodule

// File: filelist.f
rtl/psp_pkg.sv
rtl/process_syscall_profile_table_unit.sv
test/tb_top.sv
